/* rtl/ipc_pkg.sv */
// Shared types and constants for the impedance passivity controller.
// No dependencies; imported by every module of the block.
package ipc_pkg;

    // Fixed field widths of the ports.
    localparam int SAMPLE_FIELD_W  = 32;
    localparam int ENERGY_FIELD_W  = 64;
    localparam int PARTNER_FIELD_W = 63;
    localparam int PERIOD_W        = 32;

    // Defaults for the top level parameters.
    localparam int DFLT_SAMPLE_WIDTH = 32;
    localparam int DFLT_ENERGY_WIDTH = 64;

    localparam logic [PERIOD_W-1:0] PERIOD_RESET = 32'd4294967;

    // Serial arithmetic: one multiplier bit and one quotient bit per cycle.
    localparam int MUL_STEPS = PERIOD_W;
    localparam int FRAC_W    = 32;
    localparam int DIV_STEPS = ENERGY_FIELD_W + FRAC_W;

    typedef enum logic [2:0] {
        S_IDLE,
        S_MUL_P,
        S_MUL_E,
        S_UPDATE,
        S_CHECK,
        S_MUL_D,
        S_DIV,
        S_DONE
    } t_state;

endpackage

/* rtl/impedance_passivity_controller.sv */
// Impedance-side passivity observer and controller, one word in, one word out.
// Each word runs two serial multiplies (power, then energy) plus control;
// a corrected force adds a third multiply (the divisor) and a divide.
// Throughput is one word at a time, set by the shared serial multiplier and divider.
// Reset is synchronous, active low: energies clear, sample period returns to 4294967.
module impedance_passivity_controller
    import ipc_pkg::*;
#(
    parameter int SAMPLE_WIDTH = DFLT_SAMPLE_WIDTH,
    parameter int ENERGY_WIDTH = DFLT_ENERGY_WIDTH
) (
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    // Configuration: the sample period, unsigned Q0.32 seconds.
    input  logic                              i_cfg_valid,
    input  logic [PERIOD_W-1:0]               i_cfg_data,
    output logic                              o_cfg_ready,
    // Input words.
    input  logic                              i_in_valid,
    output logic                              o_in_stall,
    input  logic signed [SAMPLE_FIELD_W-1:0]  i_force_req,
    input  logic signed [SAMPLE_FIELD_W-1:0]  i_velocity,
    input  logic [PARTNER_FIELD_W-1:0]        i_partner_input_energy,
    // Result words.
    output logic                              o_out_valid,
    input  logic                              i_out_stall,
    output logic signed [SAMPLE_FIELD_W-1:0]  o_force_out,
    output logic [PARTNER_FIELD_W-1:0]        o_input_energy_out,
    output logic signed [ENERGY_FIELD_W-1:0]  o_output_energy_observed,
    output logic signed [ENERGY_FIELD_W-1:0]  o_output_energy_out,
    output logic                              o_force_modified
);

    localparam int SW = SAMPLE_WIDTH;
    localparam int EW = ENERGY_WIDTH;

    // Saturation bounds: input energy stays below 2^(EW-1), output energy
    // magnitude stays at or below 2^(EW-1).
    localparam logic [ENERGY_FIELD_W:0] IN_MAX  = (65'(1) << (EW - 1)) - 65'(1);
    localparam logic [ENERGY_FIELD_W:0] OUT_MAX = 65'(1) << (EW - 1);
    localparam logic [SW-1:0]           SHALF   = SW'(1) << (SW - 1);

    t_state r_state;
    t_state n_state;

    // Architectural state. Output energy is kept as a magnitude; the
    // port value is its negation.
    logic [PERIOD_W-1:0] r_period;
    logic [EW-2:0]       r_in_energy;
    logic [EW-1:0]       r_out_mag;

    // Per-word working registers.
    logic [EW-1:0]                r_prev_mag;
    logic [EW-1:0]                r_obs_mag;
    logic [PARTNER_FIELD_W-1:0]   r_partner;
    logic [SW-1:0]                r_vmag;
    logic                         r_vneg;
    logic                         r_opp;
    logic                         r_qneg;
    logic [ENERGY_FIELD_W-1:0]    r_nmag;
    logic signed [SAMPLE_FIELD_W-1:0] r_force;
    logic                         r_mod;

    // Output register.
    logic                              r_out_valid;
    logic signed [SAMPLE_FIELD_W-1:0]  r_o_force;
    logic [PARTNER_FIELD_W-1:0]        r_o_in_energy;
    logic signed [ENERGY_FIELD_W-1:0]  r_o_obs;
    logic signed [ENERGY_FIELD_W-1:0]  r_o_out;
    logic                              r_o_mod;

    // Shared serial units.
    logic                      mul_start;
    logic [ENERGY_FIELD_W-1:0] mul_mcand;
    logic [MUL_STEPS-1:0]      mul_mplier;
    logic                      mul_done;
    logic [ENERGY_FIELD_W-1:0] mul_hi;
    logic [MUL_STEPS-1:0]      mul_lo;
    logic                      div_start;
    logic                      div_done;
    logic [SW-1:0]             div_quo;
    logic [SW-1:0]             div_lim;
    logic [ENERGY_FIELD_W-1:0] mul_low64;

    // Input sample split into sign and magnitude over the low SW bits.
    logic [SW-1:0] in_f;
    logic [SW-1:0] in_v;
    logic [SW-1:0] in_fmag;
    logic [SW-1:0] in_vmag;
    logic          in_accept;
    logic          out_take;
    logic          out_load;

    // Update and correction arithmetic.
    logic [ENERGY_FIELD_W:0]   upd_in_sum;
    logic [ENERGY_FIELD_W:0]   upd_out_sum;
    logic [EW-2:0]             upd_in_new;
    logic [EW-1:0]             upd_out_new;
    logic [ENERGY_FIELD_W-1:0] chk_partner;
    logic [ENERGY_FIELD_W-1:0] chk_prev;
    logic                      chk_corr;
    logic                      chk_nneg;
    logic [EW-1:0]             corr_mag;
    logic [SW-1:0]             new_force;

    assign in_f      = i_force_req[SW-1:0];
    assign in_v      = i_velocity[SW-1:0];
    assign in_fmag   = in_f[SW-1] ? SW'(-in_f) : in_f;
    assign in_vmag   = in_v[SW-1] ? SW'(-in_v) : in_v;
    assign in_accept = i_in_valid && !o_in_stall;
    assign out_take  = r_out_valid && !i_out_stall;
    assign mul_low64 = {mul_hi[ENERGY_FIELD_W-MUL_STEPS-1:0], mul_lo};

    // The new energies after adding this word's energy, with saturation.
    assign upd_in_sum  = ENERGY_FIELD_W'(r_in_energy) + {1'b0, mul_hi};
    assign upd_out_sum = ENERGY_FIELD_W'(r_out_mag) + {1'b0, mul_hi};
    assign upd_in_new  = (upd_in_sum > IN_MAX) ? IN_MAX[EW-2:0] : upd_in_sum[EW-2:0];
    assign upd_out_new = (upd_out_sum > OUT_MAX) ? OUT_MAX[EW-1:0] : upd_out_sum[EW-1:0];

    // The controller acts when the observed output energy exceeds what the
    // partner has put in and the velocity is nonzero.
    assign chk_partner = ENERGY_FIELD_W'(r_partner);
    assign chk_prev    = ENERGY_FIELD_W'(r_prev_mag);
    assign chk_corr    = (ENERGY_FIELD_W'(r_out_mag) > chk_partner) && (r_vmag != '0);
    assign chk_nneg    = chk_prev > chk_partner;

    assign corr_mag  = ({1'b0, chk_partner} > OUT_MAX) ? OUT_MAX[EW-1:0] : EW'(r_partner);
    assign div_lim   = r_qneg ? SHALF : SHALF - SW'(1);
    assign new_force = r_qneg ? SW'(-div_quo) : div_quo;

    assign o_cfg_ready = 1'b1;
    assign o_in_stall  = (r_state != S_IDLE);

    ipc_serial_mul u_mul (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (mul_start),
        .i_mcand   (mul_mcand),
        .i_mplier  (mul_mplier),
        .o_done    (mul_done),
        .o_prod_hi (mul_hi),
        .o_prod_lo (mul_lo)
    );

    ipc_serial_div #(
        .QW (SW)
    ) u_div (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (div_start),
        .i_num   (r_nmag),
        .i_den   (mul_low64),
        .i_lim   (div_lim),
        .o_done  (div_done),
        .o_quo   (div_quo)
    );

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // Sequencer: power, then energy, then the optional force correction.
    always_comb begin
        n_state    = r_state;
        mul_start  = 1'b0;
        mul_mcand  = '0;
        mul_mplier = r_period;
        div_start  = 1'b0;
        out_load   = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    // Power magnitude |F| * |V|.
                    mul_start  = 1'b1;
                    mul_mcand  = ENERGY_FIELD_W'(in_fmag);
                    mul_mplier = MUL_STEPS'(in_vmag);
                    n_state    = S_MUL_P;
                end
            end
            S_MUL_P: begin
                if (mul_done) begin
                    // Energy magnitude |P| * period / 2^32.
                    mul_start = 1'b1;
                    mul_mcand = mul_low64;
                    n_state   = S_MUL_E;
                end
            end
            S_MUL_E: begin
                if (mul_done) begin
                    n_state = S_UPDATE;
                end
            end
            S_UPDATE: begin
                n_state = S_CHECK;
            end
            S_CHECK: begin
                if (chk_corr) begin
                    // Divisor |V| * period.
                    mul_start = 1'b1;
                    mul_mcand = ENERGY_FIELD_W'(r_vmag);
                    n_state   = S_MUL_D;
                end else begin
                    n_state = S_DONE;
                end
            end
            S_MUL_D: begin
                if (mul_done) begin
                    div_start = 1'b1;
                    n_state   = S_DIV;
                end
            end
            S_DIV: begin
                if (div_done) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                if (!r_out_valid || !i_out_stall) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    // Configuration and the energy state.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_period    <= PERIOD_RESET;
            r_in_energy <= '0;
            r_out_mag   <= '0;
        end else begin
            if (i_cfg_valid) begin
                r_period <= i_cfg_data;
            end
            if (r_state == S_UPDATE) begin
                // Negative power feeds input energy, positive power drains
                // output energy. Zero power adds zero either way.
                if (r_opp) begin
                    r_in_energy <= upd_in_new;
                end else begin
                    r_out_mag <= upd_out_new;
                end
            end
            if (r_state == S_DIV && div_done) begin
                r_out_mag <= corr_mag;
            end
        end
    end

    // Per-word working registers.
    always_ff @(posedge i_clk) begin
        if (in_accept) begin
            r_partner  <= i_partner_input_energy;
            r_vmag     <= in_vmag;
            r_vneg     <= in_v[SW-1];
            r_opp      <= in_f[SW-1] ^ in_v[SW-1];
            r_prev_mag <= r_out_mag;
            r_force    <= SAMPLE_FIELD_W'(signed'(in_f));
            r_mod      <= 1'b0;
        end
        if (r_state == S_UPDATE) begin
            r_obs_mag <= r_opp ? r_out_mag : upd_out_new;
        end
        if (r_state == S_CHECK) begin
            // Numerator restores this word's drain: partner plus previous
            // output energy, which is partner minus the previous magnitude.
            r_nmag <= chk_nneg ? chk_prev - chk_partner : chk_partner - chk_prev;
            r_qneg <= chk_nneg ^ r_vneg;
        end
        if (r_state == S_DIV && div_done) begin
            r_force <= SAMPLE_FIELD_W'(signed'(new_force));
            r_mod   <= 1'b1;
        end
    end

    // Output register: lets the next word start while this one waits.
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_load) begin
            r_out_valid <= 1'b1;
        end else if (out_take) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (out_load) begin
            r_o_force     <= r_force;
            r_o_in_energy <= PARTNER_FIELD_W'(r_in_energy);
            r_o_obs       <= -ENERGY_FIELD_W'(r_obs_mag);
            r_o_out       <= -ENERGY_FIELD_W'(r_out_mag);
            r_o_mod       <= r_mod;
        end
    end

    assign o_out_valid              = r_out_valid;
    assign o_force_out              = r_o_force;
    assign o_input_energy_out       = r_o_in_energy;
    assign o_output_energy_observed = r_o_obs;
    assign o_output_energy_out      = r_o_out;
    assign o_force_modified         = r_o_mod;

`ifndef SYNTH
    a_mul_done_in_mul_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        mul_done |-> (r_state == S_MUL_P || r_state == S_MUL_E || r_state == S_MUL_D))
        else $error("multiplier finished outside a multiply state");

    a_div_done_in_div_state: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        div_done |-> (r_state == S_DIV))
        else $error("divider finished outside the divide state");

    a_out_mag_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        {1'b0, ENERGY_FIELD_W'(r_out_mag)} <= OUT_MAX)
        else $error("output energy magnitude beyond saturation bound");

    a_modified_sets_partner: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_DIV && div_done) |=> (r_out_mag == corr_mag))
        else $error("corrected output energy not taken from partner energy");
`endif

endmodule

/* rtl/ipc_serial_mul.sv */
// Shift-and-add multiplier, one multiplier bit per cycle.
// Depends on ipc_pkg for the step count and operand widths.
module ipc_serial_mul
    import ipc_pkg::*;
(
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ENERGY_FIELD_W-1:0] i_mcand,
    input  logic [MUL_STEPS-1:0]      i_mplier,
    output logic                      o_done,
    output logic [ENERGY_FIELD_W-1:0] o_prod_hi,
    output logic [MUL_STEPS-1:0]      o_prod_lo
);

    localparam int CNT_W = $clog2(MUL_STEPS);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [ENERGY_FIELD_W-1:0] r_mc;
    logic [ENERGY_FIELD_W-1:0] r_hi;
    logic [MUL_STEPS-1:0]      r_lo;
    logic [ENERGY_FIELD_W:0]   n_sum;

    // The low product bits fall into the multiplier register as it empties.
    assign n_sum = {1'b0, r_hi} + (r_lo[0] ? {1'b0, r_mc} : '0);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(MUL_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_mc <= i_mcand;
            r_hi <= '0;
            r_lo <= i_mplier;
        end else if (r_busy) begin
            r_hi <= n_sum[ENERGY_FIELD_W:1];
            r_lo <= {n_sum[0], r_lo[MUL_STEPS-1:1]};
        end
    end

    assign o_done    = r_done;
    assign o_prod_hi = r_hi;
    assign o_prod_lo = r_lo;

endmodule

/* rtl/ipc_serial_div.sv */
// Restoring divider for floor(n * 2^32 / d), one quotient bit per cycle,
// with the quotient clamped to a limit. Depends on ipc_pkg.
module ipc_serial_div
    import ipc_pkg::*;
#(
    parameter int QW = DFLT_SAMPLE_WIDTH
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [ENERGY_FIELD_W-1:0] i_num,
    input  logic [ENERGY_FIELD_W-1:0] i_den,
    input  logic [QW-1:0]             i_lim,
    output logic                      o_done,
    output logic [QW-1:0]             o_quo
);

    localparam int CNT_W = $clog2(DIV_STEPS);

    logic                      r_busy;
    logic                      r_done;
    logic [CNT_W-1:0]          r_cnt;
    logic [ENERGY_FIELD_W-1:0] r_num;
    logic [ENERGY_FIELD_W-1:0] r_den;
    logic [ENERGY_FIELD_W-1:0] r_rem;
    logic [QW-1:0]             r_quo;
    logic [QW-1:0]             r_lim;
    logic                      r_sat;
    logic                      r_nzero;
    logic [ENERGY_FIELD_W:0]   n_shift;
    logic                      n_ge;
    logic [QW:0]               n_quo;

    // The numerator bits come first, then the fractional zeros.
    assign n_shift = {r_rem, r_num[ENERGY_FIELD_W-1]};
    assign n_ge    = n_shift >= {1'b0, r_den};
    assign n_quo   = {r_quo, n_ge};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                r_cnt <= r_cnt + CNT_W'(1);
                if (r_cnt == CNT_W'(DIV_STEPS - 1)) begin
                    r_busy <= 1'b0;
                    r_done <= 1'b1;
                end
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_num   <= i_num;
            r_den   <= i_den;
            r_rem   <= '0;
            r_quo   <= '0;
            r_lim   <= i_lim;
            r_sat   <= 1'b0;
            r_nzero <= (i_num == '0);
        end else if (r_busy) begin
            r_num <= {r_num[ENERGY_FIELD_W-2:0], 1'b0};
            if (n_ge) begin
                r_rem <= ENERGY_FIELD_W'(n_shift - {1'b0, r_den});
            end else begin
                r_rem <= n_shift[ENERGY_FIELD_W-1:0];
            end
            // The quotient only grows, so passing the limit once is final.
            if (n_quo > {1'b0, r_lim}) begin
                r_sat <= 1'b1;
            end
            r_quo <= n_quo[QW-1:0];
        end
    end

    // A zero divisor saturates unless the numerator is zero as well.
    assign o_quo  = r_nzero ? '0 : (r_sat ? r_lim : r_quo);
    assign o_done = r_done;

endmodule

/* test/ipc_checker.sv */
// Checker for the impedance passivity controller: watches the config, input and
// result channels, predicts each result word and compares field by field. Uses ipc_pkg.
`timescale 1ns / 100ps
module ipc_checker
    import ipc_pkg::*;
(
    input  logic                              i_clk,
    input  logic                              i_rst_n,
    input  logic                              i_cfg_valid,
    input  logic [PERIOD_W-1:0]               i_cfg_data,
    input  logic                              i_cfg_ready,
    input  logic                              i_in_valid,
    input  logic                              i_in_stall,
    input  logic signed [SAMPLE_FIELD_W-1:0]  i_force_req,
    input  logic signed [SAMPLE_FIELD_W-1:0]  i_velocity,
    input  logic [PARTNER_FIELD_W-1:0]        i_partner,
    input  logic                              i_out_valid,
    input  logic                              i_out_stall,
    input  logic signed [SAMPLE_FIELD_W-1:0]  i_force_out,
    input  logic [PARTNER_FIELD_W-1:0]        i_input_energy_out,
    input  logic signed [ENERGY_FIELD_W-1:0]  i_observed,
    input  logic signed [ENERGY_FIELD_W-1:0]  i_output_energy_out,
    input  logic                              i_force_modified,
    output int                                o_errors,
    output int                                o_pending,
    output int                                o_results,
    output int                                o_corrections
);

    typedef struct packed {
        logic [31:0] force_v;
        logic [62:0] in_energy;
        logic [63:0] observed;
        logic [63:0] out_energy;
        logic        modified;
    } t_energy_word;

    localparam logic [63:0] EHALF = 64'h8000_0000_0000_0000;

    t_energy_word expected_words[$];
    logic [31:0]  period;
    logic [63:0]  in_energy;
    logic [63:0]  out_energy;

    assign o_pending = expected_words.size();

    function automatic logic [63:0] quotient_sat(logic [63:0] num, logic [63:0] den,
                                                  logic [63:0] lim);
        logic [127:0] q;
        if (den == 0) return (num != 0) ? lim : 64'd0;
        q = {num, 32'd0} / den;
        return (q > lim) ? lim : q[63:0];
    endfunction

    // Advances the energy bookkeeping by one sample and returns the result word.
    function automatic t_energy_word passivity_step(logic [31:0] f, logic [31:0] v,
                                                    logic [62:0] partner);
        t_energy_word w;
        logic        fneg, vneg, nneg, qneg;
        logic [63:0] fm, vm, pm, e, prev_mag, cur_mag, s, nmag, lim, q, p64;
        logic [95:0] prod;
        fneg = f[31];
        vneg = v[31];
        fm = fneg ? {32'd0, -f} : {32'd0, f};
        vm = vneg ? {32'd0, -v} : {32'd0, v};
        pm = fm * vm;
        prod = pm * period;
        e = prod[95:32];
        p64 = {1'b0, partner};
        prev_mag = -out_energy;
        cur_mag = prev_mag;
        w.force_v = f;
        w.modified = 1'b0;
        if (pm != 0) begin
            if (fneg != vneg) begin
                s = in_energy + e;
                in_energy = (s > EHALF - 1) ? EHALF - 1 : s;
            end else begin
                s = prev_mag + e;
                cur_mag = (s > EHALF) ? EHALF : s;
                out_energy = -cur_mag;
            end
        end
        w.observed = out_energy;
        if (cur_mag > p64 && vm != 0) begin
            nneg = prev_mag > p64;
            nmag = nneg ? prev_mag - p64 : p64 - prev_mag;
            qneg = nneg != vneg;
            lim = qneg ? 64'h8000_0000 : 64'h7FFF_FFFF;
            q = quotient_sat(nmag, vm * period, lim);
            w.force_v = qneg ? -q[31:0] : q[31:0];
            out_energy = -p64;
            w.modified = 1'b1;
        end
        w.in_energy = in_energy[62:0];
        w.out_energy = out_energy;
        return w;
    endfunction

    always @(posedge i_clk) begin
        t_energy_word got, want;
        if (!i_rst_n) begin
            period = PERIOD_RESET;
            in_energy = '0;
            out_energy = '0;
            expected_words.delete();
            o_errors <= 0;
            o_results <= 0;
            o_corrections <= 0;
        end else begin
            if (i_cfg_valid && i_cfg_ready) period = i_cfg_data;
            if (i_out_valid && !i_out_stall) begin
                got = {i_force_out, i_input_energy_out, i_observed, i_output_energy_out,
                       i_force_modified};
                o_results <= o_results + 1;
                if (expected_words.size() == 0) begin
                    if (o_errors < 10) $display("ERROR: result word with none expected");
                    o_errors <= o_errors + 1;
                end else begin
                    want = expected_words.pop_front();
                    if (want.modified) o_corrections <= o_corrections + 1;
                    if (got != want) begin
                        if (o_errors < 10)
                            $display({"ERROR: exp f=%h ie=%h ob=%h oe=%h m=%b ",
                                      "got f=%h ie=%h ob=%h oe=%h m=%b"},
                                want.force_v, want.in_energy, want.observed, want.out_energy,
                                want.modified, got.force_v, got.in_energy, got.observed,
                                got.out_energy, got.modified);
                        o_errors <= o_errors + 1;
                    end
                end
            end
            if (i_in_valid && !i_in_stall)
                expected_words.push_back(passivity_step(i_force_req, i_velocity, i_partner));
        end
    end

endmodule

/* test/tb_top.sv */
// Testbench top for impedance_passivity_controller: clock, reset, stimulus and verdict.
// Depends on ipc_pkg, the block and ipc_checker, which does all prediction and comparing.
`timescale 1ns / 100ps
module tb_top;
    import ipc_pkg::*;

    localparam int RANDOM_WORDS = 1030;
    localparam int STALL_LIMIT  = 5000;

    logic                       clk = 1'b0;
    logic                       rst_n = 1'b0;
    logic                       cfg_valid = 1'b0;
    logic [PERIOD_W-1:0]        cfg_data = '0;
    logic                       cfg_ready;
    logic                       in_valid = 1'b0;
    logic                       in_stall;
    logic signed [31:0]         force_req = '0;
    logic signed [31:0]         velocity = '0;
    logic [62:0]                partner = '0;
    logic                       out_valid;
    logic                       out_stall = 1'b0;
    logic signed [31:0]         force_out;
    logic [62:0]                input_energy_out;
    logic signed [63:0]         observed, output_energy_out;
    logic                       force_modified;
    int                         errors, pending, results, corrections;
    int                         sent = 0;
    int                         idle_cycles = 0;
    bit                         calm = 1'b0;   // When set, neither side idles.
    bit                         stim_done = 1'b0;

    always begin
        #5 clk = 1'b1;
        #5 clk = 1'b0;
    end

    impedance_passivity_controller dut (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_data(cfg_data), .o_cfg_ready(cfg_ready),
        .i_in_valid(in_valid), .o_in_stall(in_stall),
        .i_force_req(force_req), .i_velocity(velocity), .i_partner_input_energy(partner),
        .o_out_valid(out_valid), .i_out_stall(out_stall),
        .o_force_out(force_out), .o_input_energy_out(input_energy_out),
        .o_output_energy_observed(observed), .o_output_energy_out(output_energy_out),
        .o_force_modified(force_modified)
    );

    ipc_checker u_checker (
        .i_clk(clk), .i_rst_n(rst_n),
        .i_cfg_valid(cfg_valid), .i_cfg_data(cfg_data), .i_cfg_ready(cfg_ready),
        .i_in_valid(in_valid), .i_in_stall(in_stall),
        .i_force_req(force_req), .i_velocity(velocity), .i_partner(partner),
        .i_out_valid(out_valid), .i_out_stall(out_stall),
        .i_force_out(force_out), .i_input_energy_out(input_energy_out),
        .i_observed(observed), .i_output_energy_out(output_energy_out),
        .i_force_modified(force_modified),
        .o_errors(errors), .o_pending(pending), .o_results(results),
        .o_corrections(corrections)
    );

    // The result side stalls at random, except during calm stretches.
    always @(negedge clk) begin
        out_stall <= !calm && ($urandom_range(99) < 30);
    end

    // Watchdog: any cycle with no word moved on any channel counts toward the limit.
    always @(posedge clk) begin
        if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
            || !rst_n || stim_done)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= STALL_LIMIT) begin
            $display("tb_top: FAIL");
            $finish;
        end
    end

    // Sends one input word; random idle gaps precede it unless calm. Valid stays
    // high after the word is taken until the next word or an idle gap replaces it.
    task automatic send_word(logic [31:0] f, logic [31:0] v, logic [62:0] p);
        while (!calm && $urandom_range(99) < 30) begin
            in_valid <= 1'b0;
            @(negedge clk);
        end
        in_valid <= 1'b1;
        force_req <= f;
        velocity <= v;
        partner <= p;
        @(posedge clk);
        while (in_stall) @(posedge clk);
        @(negedge clk);
        sent++;
    endtask

    task automatic drain;
        in_valid <= 1'b0;
        while (pending != 0) @(negedge clk);
        repeat (250) @(negedge clk);
    endtask

    // Period writes happen only with the block drained.
    task automatic set_period(logic [31:0] value);
        drain();
        cfg_valid <= 1'b1;
        cfg_data <= value;
        @(posedge clk);
        while (!cfg_ready) @(posedge clk);
        @(negedge clk);
        cfg_valid <= 1'b0;
    endtask

    // Random sample: mostly moderate magnitudes so energies move both ways,
    // sometimes full-range bits, sometimes zeros and extremes.
    function automatic logic [31:0] rand_sample();
        case ($urandom_range(9))
            0: return 32'd0;
            1: return $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
            2, 3: return $urandom();
            default: return $signed($urandom_range(32'h0010_0000)) - 32'sh0008_0000;
        endcase
    endfunction

    function automatic logic [62:0] rand_partner();
        case ($urandom_range(7))
            0: return '0;
            1: return 63'h7FFF_FFFF_FFFF_FFFF;
            2: return 63'({$urandom(), $urandom()});
            default: return {15'd0, 16'($urandom_range(32'h0000_FFFF)), $urandom()};
        endcase
    endfunction

    task automatic random_block(int count);
        for (int i = 0; i < count; i++) send_word(rand_sample(), rand_sample(), rand_partner());
    endtask

    initial begin
        repeat (11) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        // Directed: extremes, both power signs, zero velocity, correction with
        // large and small partner energy, saturating force.
        send_word(32'h0001_0000, 32'h0001_0000, 63'd0);
        send_word(32'hFFFF_0000, 32'h0001_0000, 63'd0);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 63'd0);
        send_word(32'h8000_0000, 32'h8000_0000, 63'h7FFF_FFFF_FFFF_FFFF);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 63'd1);
        send_word(32'h7FFF_FFFF, 32'h0000_0000, 63'd0);
        send_word(32'h0000_0000, 32'h8000_0000, 63'd0);
        send_word(32'h0050_0000, 32'hFFFF_FFFF, 63'd5);
        send_word(32'h0010_0000, 32'h0000_0001, 63'h7FFF_FFFF_FFFF_FFFF);
        set_period(32'hFFFF_FFFF);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 63'd0);
        send_word(32'h8000_0000, 32'h8000_0000, 63'd0);
        send_word(32'h8000_0000, 32'h7FFF_FFFF, 63'd0);
        send_word(32'h7FFF_FFFF, 32'h8000_0000, 63'h7FFF_FFFF_FFFF_FFFF);
        set_period(32'd1);
        send_word(32'h0100_0000, 32'hFF00_0000, 63'd0);
        send_word(32'h0100_0000, 32'h0000_0001, 63'd0);
        set_period(32'd0);
        send_word(32'h7FFF_FFFF, 32'h7FFF_FFFF, 63'd0);
        send_word(32'h0001_0000, 32'hFFFF_0000, 63'd0);

        // Random phases over several periods; the second one runs with no idling.
        set_period(PERIOD_RESET);
        random_block(RANDOM_WORDS / 4);
        set_period(32'h0100_0000);
        calm = 1'b1;
        random_block(RANDOM_WORDS / 4);
        calm = 1'b0;
        // Hold the sender until every result is back.
        drain();
        set_period($urandom());
        random_block(RANDOM_WORDS / 4);
        set_period(32'hFFFF_FFFF);
        random_block(RANDOM_WORDS / 4);

        drain();
        stim_done = 1'b1;
        $display("Sent %0d words, checked %0d results, %0d with a corrected force.",
                 sent, results, corrections);
        if (errors == 0 && pending == 0) begin
            $display("tb_top: PASS");
        end else begin
            $display("tb_top: FAIL");
        end
        $finish;
    end

endmodule
